>>> hw/rtl/lidar_scan_packet_parser_macros.svh
// Assertion helpers for the scan parser checker.
// Both expect signals named clk and rst in the scope of use.
`ifndef LIDAR_SCAN_PACKET_PARSER_MACROS_SVH
`define LIDAR_SCAN_PACKET_PARSER_MACROS_SVH

// Same-cycle implication.
`define LSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsp assertion failed");

// Next-cycle implication.
`define LSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsp assertion failed");

`endif

>>> hw/rtl/lsp_pkg.sv
`timescale 1ns / 1ps
package lsp_pkg;

  localparam logic [7:0] HDR_FIRST   = 8'hAA;
  localparam logic [7:0] HDR_SECOND  = 8'h55;
  localparam int         FIXED_BYTES = 10;
  localparam int         START_HI    = 5;
  localparam int         END_HI      = 7;
  localparam int         COUNT_POS   = 3;

  typedef struct packed {
    logic take_byte;
    logic rd_issue;
    logic rd_next;
  } lsp_cmd_t;

  typedef struct packed {
    logic frame_good;
    logic last_sample;
  } lsp_stat_t;

  typedef struct packed {
    logic [13:0] range_mm;
    logic        sample_good;
    logic [5:0]  sample_index;
    logic [14:0] start_angle_q6;
    logic [14:0] end_angle_q6;
    logic [7:0]  packet_type;
    logic [5:0]  samples_in_frame;
    logic        last;
  } lsp_sample_t;

endpackage

>>> hw/rtl/lsp_ifs.sv
`timescale 1ns / 1ps
interface lsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lsp_sample_if;
  logic        valid;
  logic        ready;
  logic [13:0] range_mm;
  logic        sample_good;
  logic [5:0]  sample_index;
  logic [14:0] start_angle_q6;
  logic [14:0] end_angle_q6;
  logic [7:0]  packet_type;
  logic [5:0]  samples_in_frame;
  logic        last;

  modport source (
    output valid, output range_mm, output sample_good, output sample_index,
    output start_angle_q6, output end_angle_q6, output packet_type,
    output samples_in_frame, output last, input ready
  );
  modport sink (
    input valid, input range_mm, input sample_good, input sample_index,
    input start_angle_q6, input end_angle_q6, input packet_type,
    input samples_in_frame, input last, output ready
  );
endinterface

>>> hw/rtl/lidar_scan_packet_parser.sv
`timescale 1ns / 1ps
// Scan packet parser: byte stream in, one beat per sample of each good frame out.
// rx carries one received byte per beat. The parser hunts for AA 55, then reads
// type, sample count, start and end angle words, check word and sample words,
// all little endian, and XORs every 16-bit frame word together.
// samples carries one beat per sample of a frame whose XOR is zero; the last
// beat of a frame has last set. Bad, oversized or empty frames give no beats.
// Throughput: one byte per cycle while receiving. When the last byte of a good
// frame is taken, rx.ready drops and the samples are read back from the sample
// memory, one read per result: each read is issued in the read state and its
// result is shown in the show state, which holds it while samples.ready is low.
// rx.ready returns the cycle after the last result beat. A frame of N samples
// therefore holds the byte input off until all N results are taken.
// A stalled result holds its payload steady until taken.
// Reset (rst, synchronous) returns the parser to header hunting and drops any
// readout in progress; sample memory is not cleared.
module lidar_scan_packet_parser
  import lsp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 90
) (
  input  logic        clk,
  input  logic        rst,
  lsp_byte_if.sink    rx,
  lsp_sample_if.source samples
);

  lsp_cmd_t    cmd;
  lsp_stat_t   stat;
  lsp_sample_t res;

  lsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .out_valid (samples.valid),
    .out_ready (samples.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lsp_datapath #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .rx_byte (rx.rx_byte),
    .cmd     (cmd),
    .stat    (stat),
    .res     (res)
  );

  assign samples.range_mm         = res.range_mm;
  assign samples.sample_good      = res.sample_good;
  assign samples.sample_index     = res.sample_index;
  assign samples.start_angle_q6   = res.start_angle_q6;
  assign samples.end_angle_q6     = res.end_angle_q6;
  assign samples.packet_type      = res.packet_type;
  assign samples.samples_in_frame = res.samples_in_frame;
  assign samples.last             = res.last;

endmodule

>>> hw/rtl/lsp_ctrl.sv
`timescale 1ns / 1ps
module lsp_ctrl
  import lsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  lsp_stat_t stat,
  output lsp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_RECV = 3'b001,
    ST_READ = 3'b010,
    ST_SHOW = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RECV;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd.take_byte = 1'b0;
    cmd.rd_issue  = 1'b0;
    cmd.rd_next   = 1'b0;
    unique case (state)
      ST_RECV: begin
        in_ready      = 1'b1;
        cmd.take_byte = in_valid;
        if (in_valid && stat.frame_good) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_SHOW;
      end
      ST_SHOW: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.last_sample) begin
            state_next = ST_RECV;
          end else begin
            cmd.rd_next = 1'b1;
            state_next  = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_RECV;
      end
    endcase
  end

endmodule

>>> hw/rtl/lsp_datapath.sv
`timescale 1ns / 1ps
module lsp_datapath
  import lsp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 90
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  rx_byte,
  input  lsp_cmd_t    cmd,
  output lsp_stat_t   stat,
  output lsp_sample_t res
);

  localparam int MAX_SAMPLES = (MAX_FRAME_BYTES - FIXED_BYTES) / 2;
  localparam int POS_W       = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  logic [POS_W-1:0] pos;
  logic [CNT_W-1:0] count;
  logic [7:0]       type_b;
  logic [15:0]      start_w;
  logic [15:0]      end_w;
  logic [15:0]      xor_acc;
  logic [7:0]       low_hold;
  logic [IDX_W-1:0] rd_idx;
  logic [15:0]      rd_data;
  logic [15:0]      mem [MAX_SAMPLES];

  logic [15:0]      word;
  logic [15:0]      xor_next;
  logic [POS_W-1:0] total;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] samp_off;
  logic [IDX_W-1:0] wr_addr;
  logic             in_body;
  logic             body_ok;
  logic             frame_end;
  logic             wr_en;

  assign word     = {rx_byte, low_hold};
  assign xor_next = xor_acc ^ word;
  assign total    = POS_W'(FIXED_BYTES) + {count, 1'b0};
  assign pos_inc  = pos + 1'b1;
  assign samp_off = (pos - POS_W'(FIXED_BYTES)) >> 1;
  assign wr_addr  = samp_off[IDX_W-1:0];
  assign in_body  = pos > POS_W'(COUNT_POS);
  assign body_ok  = in_body && (pos < total);
  assign frame_end = body_ok && (pos_inc == total);
  assign wr_en    = cmd.take_byte && body_ok && pos[0] && (pos >= POS_W'(FIXED_BYTES));

  assign stat.frame_good  = frame_end && (xor_next == 16'h0000) && (count != '0);
  assign stat.last_sample = (CNT_W'(rd_idx) == count - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (cmd.take_byte) begin
      priority if (pos == '0) begin
        if (rx_byte == HDR_FIRST) begin
          xor_acc  <= '0;
          low_hold <= rx_byte;
          pos      <= POS_W'(1);
        end
      end else if (pos == POS_W'(1)) begin
        if (rx_byte != HDR_SECOND) begin
          pos <= '0;
        end else begin
          xor_acc <= xor_next;
          pos     <= POS_W'(2);
        end
      end else if (pos == POS_W'(2)) begin
        type_b   <= rx_byte;
        low_hold <= rx_byte;
        pos      <= POS_W'(COUNT_POS);
      end else if (pos == POS_W'(COUNT_POS)) begin
        if (rx_byte > 8'(MAX_SAMPLES)) begin
          pos <= '0;
        end else begin
          count   <= rx_byte[CNT_W-1:0];
          xor_acc <= xor_next;
          pos     <= pos_inc;
        end
      end else if (!body_ok) begin
        pos <= '0;
      end else begin
        if (!pos[0]) begin
          low_hold <= rx_byte;
        end else begin
          xor_acc <= xor_next;
        end
        if (pos == POS_W'(START_HI)) begin
          start_w <= word;
        end
        if (pos == POS_W'(END_HI)) begin
          end_w <= word;
        end
        pos <= frame_end ? '0 : pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= word;
    end
    if (cmd.rd_issue) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (cmd.take_byte) begin
      rd_idx <= '0;
    end else if (cmd.rd_next) begin
      rd_idx <= rd_idx + 1'b1;
    end
  end

  assign res.range_mm         = rd_data[15:2];
  assign res.sample_good      = ~rd_data[0];
  assign res.sample_index     = 6'(rd_idx);
  assign res.start_angle_q6   = start_w[15:1];
  assign res.end_angle_q6     = end_w[15:1];
  assign res.packet_type      = type_b;
  assign res.samples_in_frame = 6'(count);
  assign res.last             = stat.last_sample;

endmodule

>>> hw/rtl/lsp_checker.sv
`timescale 1ns / 1ps
`include "lidar_scan_packet_parser_macros.svh"
module lsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        last,
  input logic [5:0]  sample_index,
  input logic [5:0]  samples_in_frame,
  input logic [13:0] range_mm
);

  // no byte taken while a result beat is pending
  `LSP_ASSERT_NOW(a_no_rx_in_burst, out_valid, !in_ready)
  // mid-frame beat keeps the input held off
  `LSP_ASSERT_NEXT(a_burst_holds, out_valid && out_ready && !last, !in_ready)
  // burst ends after the last beat
  `LSP_ASSERT_NEXT(a_burst_ends, out_valid && out_ready && last, !out_valid)
  // last beat carries the final index
  `LSP_ASSERT_NOW(a_last_index, out_valid && last,
                  6'(sample_index + 6'd1) == samples_in_frame)
  `LSP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
                   out_valid && $stable(range_mm))

endmodule

bind lidar_scan_packet_parser lsp_checker u_lsp_checker (
  .clk              (clk),
  .rst              (rst),
  .in_ready         (rx.ready),
  .out_valid        (samples.valid),
  .out_ready        (samples.ready),
  .last             (samples.last),
  .sample_index     (samples.sample_index),
  .samples_in_frame (samples.samples_in_frame),
  .range_mm         (samples.range_mm)
);
